// ----- rtl/core/aes128_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 shared definitions
// Payload structs, S-box tables, GF(2^8) helpers and the round transforms.
// ----------------------------------------------------------------------------
package aes128_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned REG_W      = 64;

    typedef enum logic [0:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } t_mode;

    typedef struct packed {
        logic        mode;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_item;

    // Data handed from one round cell to the next
    typedef struct packed {
        logic         vld;
        logic         dec;
        logic [127:0] state;
    } t_cell_bus;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};

    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};

    // Byte i of a 128-bit block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
        get_byte = s[127 - 8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // Next round key from the previous one
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    // Previous round key from the current one
    function automatic logic [127:0] prev_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, p3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        p3 = w3 ^ w2;
        t  = {SBOX[p3[23:16]] ^ rc, SBOX[p3[15:8]], SBOX[p3[7:0]], SBOX[p3[31:24]]};
        prev_key = {w0 ^ t, w1 ^ w0, w2 ^ w1, p3};
    endfunction

    // SubBytes + ShiftRows, encrypt direction
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        sub_shift = t;
    endfunction

    // Inverse ShiftRows + inverse SubBytes
    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = INV_SBOX[get_byte(s, r + 4*c)];
            end
        end
        inv_sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            t[127 - 32*c -: 32] = {
                xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
        end
        mix_cols = t;
    endfunction

    // Inverse MixColumns: pre-multiply by {05,00,04,00} then the forward mix
    function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, u, v;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            u  = xtime(xtime(a0 ^ a2));
            v  = xtime(xtime(a1 ^ a3));
            t[127 - 32*c -: 32] = {a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v};
        end
        inv_mix_cols = mix_cols(t);
    endfunction

endpackage

// ----- rtl/core/aes128_round_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 round and key cells
// One registered round of encryption or decryption on the passing block, and
// one registered step of the key expansion.
// ----------------------------------------------------------------------------
module aes128_round_cell import aes128_pkg::*; #(
    parameter int unsigned RND = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  t_cell_bus    i_bus,
    input  logic [127:0] i_enc_key,
    input  logic [127:0] i_dec_key,
    output t_cell_bus    o_bus
);

    localparam bit LAST = (RND == NUM_ROUNDS);

    logic         r_vld;
    logic         r_dec;
    logic [127:0] r_state;
    logic [127:0] n_state;
    logic [127:0] enc_v;
    logic [127:0] dec_v;

    // Encrypt: sub/shift, mix unless last, add key. Decrypt: inv shift/sub, add key,
    // inv mix unless last.
    always_comb begin
        enc_v = sub_shift(i_bus.state);
        if (!LAST) begin
            enc_v = mix_cols(enc_v);
        end
        enc_v = enc_v ^ i_enc_key;
        dec_v = inv_sub_shift(i_bus.state);
        dec_v = dec_v ^ i_dec_key;
        if (!LAST) begin
            dec_v = inv_mix_cols(dec_v);
        end
        n_state = i_bus.dec ? dec_v : enc_v;
    end

    // Advance valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_bus.vld;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dec   <= i_bus.dec;
            r_state <= n_state;
        end
    end

    assign o_bus = '{vld: r_vld, dec: r_dec, state: r_state};

endmodule

// Derive round key RND from round key RND-1, one register per step
module aes128_key_cell import aes128_pkg::*; #(
    parameter int unsigned RND = 1
) (
    input  logic         i_clk,
    input  logic [127:0] i_prev,
    output logic [127:0] o_key
);

    localparam logic [7:0] RC = RCON[RND-1];

    logic [127:0] r_key;

    // Advance the expansion by one round
    always_ff @(posedge i_clk) begin
        r_key <= next_key(i_prev, RC);
    end

    assign o_key = r_key;

endmodule

// ----- rtl/core/aes128_block_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Ten round cells in a row; encrypt or decrypt one block per cycle unless stalled.
// ----------------------------------------------------------------------------
// Channel | Signals                            | Direction
// in      | i_in_valid, o_in_stall, i_in_data  | item enters
// out     | o_out_valid, i_out_stall, o_out_data | result leaves
// cfg     | i_cfg_we, i_cfg_idx, i_cfg_data    | key write
//
// An input register adds the first round key (the last one when decrypting),
// then ten round cells follow. One block enters every cycle unless the input
// stalls; the cell chain sets that rate. Round keys come from a row of ten key
// cells, one register each; after reset or a key write the input stalls while
// the row settles. Reset clears all valid flags and the key. A stall on the
// output holds the whole chain; an empty slot anywhere lets the chain close up.
// ----------------------------------------------------------------------------
module aes128_block_cipher import aes128_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data
);

    logic [63:0]  r_key_high;
    logic [63:0]  r_key_low;
    logic [127:0] rk [NUM_ROUNDS+1];
    t_cell_bus    bus [NUM_ROUNDS+1];
    logic         adv [NUM_ROUNDS+1];
    logic         r_vld0;
    logic         r_dec0;
    logic [127:0] r_st0;
    logic [3:0]   r_settle;
    logic         key_busy;

    // Hold key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Count down while the key cells catch up with a new key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_settle <= 4'(NUM_ROUNDS);
        end else if (r_settle != 4'd0) begin
            r_settle <= r_settle - 4'd1;
        end
    end

    assign key_busy = (r_settle != 4'd0);

    // Key schedule, one stage of expansion per round key, reused by all blocks
    assign rk[0] = {r_key_high, r_key_low};
    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_ks
        aes128_key_cell #(.RND(g)) u_kc (
            .i_clk  (i_clk),
            .i_prev (rk[g-1]),
            .o_key  (rk[g])
        );
    end

    // Back-pressure: a stage advances if its slot is free downstream
    assign adv[NUM_ROUNDS] = !bus[NUM_ROUNDS].vld || !i_out_stall;
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_adv
        assign adv[g] = !bus[g].vld || adv[g+1];
    end
    assign o_in_stall = !adv[0] || key_busy;

    // Initial key add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (adv[0]) begin
            r_vld0 <= i_in_valid && !key_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_dec0 <= i_in_data.mode;
            r_st0  <= {i_in_data.block_high, i_in_data.block_low}
                      ^ (i_in_data.mode ? rk[NUM_ROUNDS] : rk[0]);
        end
    end

    assign bus[0] = '{vld: r_vld0, dec: r_dec0, state: r_st0};

    // Round cells
    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_rnd
        aes128_round_cell #(.RND(g)) u_rc (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv[g]),
            .i_bus     (bus[g-1]),
            .i_enc_key (rk[g]),
            .i_dec_key (rk[NUM_ROUNDS - g]),
            .o_bus     (bus[g])
        );
    end

    assign o_out_valid = bus[NUM_ROUNDS].vld;
    assign o_out_data  = '{result_high: bus[NUM_ROUNDS].state[127:64],
                           result_low:  bus[NUM_ROUNDS].state[63:0]};

endmodule

// ----- test/aes128_block_cipher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives encrypt and decrypt blocks under several keys and idling patterns,
// predicts each result with a behavioral cipher and checks transfers in order.
// ----------------------------------------------------------------------------
module aes128_block_cipher_tb;
    import aes128_pkg::*;

    localparam int LATENCY = 11;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_data;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [REG_W-1:0] i_cfg_data;

    aes128_block_cipher uut (.*);

    // Behavioral cipher state
    logic [63:0] key_hi_q, key_lo_q;
    logic [7:0]  sbox_fwd [256];
    logic [7:0]  sbox_inv [256];

    t_in_item  block_q [$];
    t_out_item cipher_q [$];
    int        err_count;
    int        send_idle_pct, recv_stall_pct;
    bit        hold_send;
    int        wait_cnt;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    // GF(2^8) multiply
    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // Compute one cipher block from the current key copy
    function automatic t_out_item cipher_block(t_in_item it);
        logic [7:0] rk [11][16];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] rc;
        logic [7:0] fm [4];
        logic [7:0] im [4];
        logic [7:0] acc;
        t_out_item  res;
        fm = '{8'h02, 8'h03, 8'h01, 8'h01};
        im = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        for (int i = 0; i < 8; i++) begin
            rk[0][i]     = key_hi_q[63 - 8*i -: 8];
            rk[0][i + 8] = key_lo_q[63 - 8*i -: 8];
            s[i]         = it.block_high[63 - 8*i -: 8];
            s[i + 8]     = it.block_low[63 - 8*i -: 8];
        end
        // Expand the key schedule
        rc = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            rk[r][0] = rk[r-1][0] ^ sbox_fwd[rk[r-1][13]] ^ rc;
            rk[r][1] = rk[r-1][1] ^ sbox_fwd[rk[r-1][14]];
            rk[r][2] = rk[r-1][2] ^ sbox_fwd[rk[r-1][15]];
            rk[r][3] = rk[r-1][3] ^ sbox_fwd[rk[r-1][12]];
            for (int i = 4; i < 16; i++) rk[r][i] = rk[r-1][i] ^ rk[r][i-4];
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
        end
        if (it.mode == MODE_ENC) begin
            for (int i = 0; i < 16; i++) s[i] ^= rk[0][i];
            for (int r = 1; r <= 10; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        t[w + 4*c] = sbox_fwd[s[w + 4*((c + w) % 4)]];
                s = t;
                if (r < 10) begin
                    for (int c = 0; c < 4; c++)
                        for (int w = 0; w < 4; w++) begin
                            acc = 8'h00;
                            for (int k = 0; k < 4; k++)
                                acc ^= gmul(fm[(k - w + 4) % 4], s[4*c + k]);
                            t[4*c + w] = acc;
                        end
                    s = t;
                end
                for (int i = 0; i < 16; i++) s[i] ^= rk[r][i];
            end
        end else begin
            for (int r = 10; r >= 1; r--) begin
                for (int i = 0; i < 16; i++) s[i] ^= rk[r][i];
                if (r < 10) begin
                    for (int c = 0; c < 4; c++)
                        for (int w = 0; w < 4; w++) begin
                            acc = 8'h00;
                            for (int k = 0; k < 4; k++)
                                acc ^= gmul(im[(k - w + 4) % 4], s[4*c + k]);
                            t[4*c + w] = acc;
                        end
                    s = t;
                end
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        t[w + 4*((c + w) % 4)] = sbox_inv[s[w + 4*c]];
                s = t;
            end
            for (int i = 0; i < 16; i++) s[i] ^= rk[0][i];
        end
        for (int i = 0; i < 8; i++) begin
            res.result_high[63 - 8*i -: 8] = s[i];
            res.result_low[63 - 8*i -: 8]  = s[i + 8];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Build the S-boxes from field arithmetic, independent of the package tables
    task automatic build_sboxes();
        logic [7:0] inv, x, b;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h00;
            for (int c = 1; c < 256; c++)
                if (gmul(a[7:0], c[7:0]) == 8'h01) inv = c[7:0];
            x = inv;
            b = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
                ^ {x[3:0], x[7:4]} ^ 8'h63;
            sbox_fwd[a] = b;
            sbox_inv[b] = a[7:0];
        end
    endtask

    // Driver: present queued blocks, hold a stalled payload
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                cipher_q.push_back(cipher_block(i_in_data));
                void'(block_q.pop_front());
            end
            if (block_q.size() > 0 && !hold_send
                    && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= block_q[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch("unexpected transfer", o_out_data.result_high, 64'h0);
                end else begin
                    if (o_out_data.result_high !== cipher_q[0].result_high)
                        report_mismatch("result_high", o_out_data.result_high,
                                        cipher_q[0].result_high);
                    if (o_out_data.result_low !== cipher_q[0].result_low)
                        report_mismatch("result_low", o_out_data.result_low,
                                        cipher_q[0].result_low);
                    void'(cipher_q.pop_front());
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic push_block(t_mode m, logic [63:0] hi, logic [63:0] lo);
        t_in_item it;
        it.mode       = m;
        it.block_high = hi;
        it.block_low  = lo;
        block_q.push_back(it);
    endtask

    // Wait until every block is through, then let the chain drain
    task automatic drain();
        while (block_q.size() != 0 || i_in_valid || cipher_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_key(logic [63:0] hi, logic [63:0] lo);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KEY_HIGH;
        i_cfg_data <= hi;
        key_hi_q    = hi;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEY_LOW;
        i_cfg_data <= lo;
        key_lo_q    = lo;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_blocks(int n);
        logic [63:0] hi, lo;
        for (int i = 0; i < n; i++) begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            push_block($urandom_range(1) ? MODE_DEC : MODE_ENC, hi, lo);
        end
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_KEY_HIGH;
        i_cfg_data     = '0;
        key_hi_q       = '0;
        key_lo_q       = '0;
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_send      = 1'b1;
        build_sboxes();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset key, extremes, both modes
        push_block(MODE_ENC, 64'h0, 64'h0);
        push_block(MODE_DEC, 64'h0, 64'h0);
        push_block(MODE_ENC, '1, '1);
        push_block(MODE_DEC, '1, '1);
        hold_send = 1'b0;
        drain();

        // Standard vector key, then all-ones key
        write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        push_block(MODE_ENC, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
        push_block(MODE_DEC, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
        push_block(MODE_ENC, 64'h8000000000000000, 64'h0000000000000001);
        push_block(MODE_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain();
        write_key('1, '1);
        push_block(MODE_ENC, 64'h0, '1);
        push_block(MODE_DEC, '1, 64'h0);
        random_blocks(4);
        drain();

        // Random phases under varying idling and keys
        for (int ph = 0; ph < 5; ph++) begin
            write_key({$urandom, $urandom}, {$urandom, $urandom});
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            random_blocks(40);
            // Pause the sender until the pipeline empties, then resume
            if (ph == 4) begin
                while (block_q.size() > 20) @(posedge i_clk);
                hold_send = 1'b1;
                while (i_in_valid || cipher_q.size() != 0) @(posedge i_clk);
                hold_send = 1'b0;
            end
            drain();
        end
        write_key(64'h0, 64'h0);
        send_idle_pct = 10; recv_stall_pct = 10;
        random_blocks(170);
        drain();

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
